// ===== rtl/tga_rle_packet_encoder_macros.svh =====
// assertion helpers for the rle packet encoder, clocked on clk_i, off during reset
`ifndef TGA_RLE_PACKET_ENCODER_MACROS_SVH
`define TGA_RLE_PACKET_ENCODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TRLE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold
`define TRLE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/trle_pkg.sv =====
package trle_pkg;

  localparam int unsigned MaxPacketDef    = 128;
  localparam int unsigned PixPerResultDef = 4;
  localparam int unsigned PixelW          = 32;
  localparam int unsigned BppW            = 3;
  localparam int unsigned HdrW            = 8;
  localparam int unsigned CountW          = 3;
  localparam int unsigned WordsPerResult  = 4;
  localparam int unsigned CmdCountW       = 8;
  localparam int unsigned QueueDepth      = 4;

  localparam logic [HdrW-1:0] RunBias  = 8'd127;
  localparam logic [BppW-1:0] BppReset = 3'd3;

  typedef struct packed {
    logic [PixelW-1:0] pixel_value;
    logic              image_last;
  } pix_in_t;

  typedef struct packed {
    logic              is_header;
    logic [HdrW-1:0]   header_byte;
    logic [CountW-1:0] pixel_count;
    logic [PixelW-1:0] pixel_a;
    logic [PixelW-1:0] pixel_b;
    logic [PixelW-1:0] pixel_c;
    logic [PixelW-1:0] pixel_d;
    logic              last_of_run;
    logic              image_done;
  } pkt_out_t;

  // one packet to send: run packets carry their pixel, raw ones point at a buffer bank
  typedef struct packed {
    logic                 run;
    logic [CmdCountW-1:0] count;
    logic [PixelW-1:0]    pixel;
    logic                 bank;
    logic                 last_of_run;
    logic                 image_done;
  } cmd_t;

  typedef struct packed {
    logic push0;
    logic push1;
    cmd_t cmd0;
    cmd_t cmd1;
  } q_push_t;

  typedef struct packed {
    logic raw_done;
    logic done_bank;
    logic rd_active;
    logic rd_bank;
  } back_stat_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackHdr,
    BackRunPx,
    BackRaw
  } back_state_e;

  function automatic logic [PixelW-1:0] byte_mask(input logic [BppW-1:0] bpp);
    logic [PixelW-1:0] m;
    m = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < int'(bpp)) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/trle_ram.sv =====
module trle_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/trle_front.sv =====
module trle_front #(
  parameter int unsigned MaxPacket = 128,
  localparam int unsigned IdxW = $clog2(MaxPacket)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [trle_pkg::BppW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  trle_pkg::pix_in_t             in_data_i,
  input  logic                          q_room_i,
  output trle_pkg::q_push_t             push_o,
  output logic                          ram_we_o,
  output logic [IdxW:0]                 ram_waddr_o,
  output logic [trle_pkg::PixelW-1:0]   ram_wdata_o,
  input  trle_pkg::back_stat_t          stat_i
);
  import trle_pkg::*;

  logic [BppW-1:0]      bpp_q;
  logic [PixelW-1:0]    held_q;
  logic [PixelW-1:0]    pix;
  logic                 held_valid_q, held_valid_d;
  logic                 run_q, run_d;
  logic                 bank_q, bank_d;
  logic [CmdCountW-1:0] len_q, len_d;
  logic [1:0]           busy_q, busy_d;
  logic                 accept, eq, flush, we;
  logic [IdxW-1:0]      widx;
  logic                 c1_v, c2_v;
  cmd_t                 c1, c2;

  // a bank still being drained by the back end is not written
  assign in_stall_o = !q_room_i || busy_q[bank_q];
  assign accept     = in_valid_i && !in_stall_o;
  assign pix        = in_data_i.pixel_value & byte_mask(bpp_q);
  assign eq         = held_valid_q && (pix == held_q);

  always_comb begin
    len_d        = len_q;
    run_d        = run_q;
    bank_d       = bank_q;
    held_valid_d = 1'b1;
    c1_v         = 1'b0;
    c1           = '0;
    c2_v         = 1'b0;
    c2           = '0;
    we           = 1'b0;
    widx         = '0;
    if (!held_valid_q) begin
      len_d = CmdCountW'(1);
      run_d = 1'b0;
      we    = 1'b1;
    end else if (len_q == CmdCountW'(1)) begin
      run_d = eq;
      we    = 1'b1;
      widx  = IdxW'(1);
      len_d = CmdCountW'(2);
    end else if (run_q) begin
      if (eq) begin
        len_d = len_q + CmdCountW'(1);
      end else begin
        c1_v     = 1'b1;
        c1.run   = 1'b1;
        c1.count = len_q;
        c1.pixel = held_q;
        we       = 1'b1;
        len_d    = CmdCountW'(1);
        run_d    = 1'b0;
      end
    end else begin
      if (eq) begin
        // raw packet ends before the pixel that opens the run
        c1_v     = 1'b1;
        c1.count = len_q - CmdCountW'(1);
        c1.bank  = bank_q;
        bank_d   = !bank_q;
        run_d    = 1'b1;
        len_d    = CmdCountW'(2);
      end else begin
        we    = 1'b1;
        widx  = len_q[IdxW-1:0];
        len_d = len_q + CmdCountW'(1);
      end
    end
    flush = (len_d >= CmdCountW'(MaxPacket)) || in_data_i.image_last;
    if (flush) begin
      c2_v           = 1'b1;
      c2.run         = run_d;
      c2.count       = len_d;
      c2.pixel       = pix;
      c2.bank        = bank_d;
      c2.last_of_run = 1'b1;
      c2.image_done  = in_data_i.image_last;
      if (!run_d) begin
        bank_d = !bank_d;
      end
      held_valid_d = 1'b0;
      len_d        = '0;
      run_d        = 1'b0;
    end else begin
      c1.last_of_run = 1'b1;
    end
  end

  always_comb begin
    push_o.push0 = accept && (c1_v || c2_v);
    push_o.push1 = accept && c1_v && c2_v;
    push_o.cmd0  = c1_v ? c1 : c2;
    push_o.cmd1  = c2;
  end

  assign ram_we_o    = accept && we;
  assign ram_waddr_o = {bank_q, widx};
  assign ram_wdata_o = pix;

  always_comb begin
    busy_d = busy_q;
    if (stat_i.raw_done) begin
      busy_d[stat_i.done_bank] = 1'b0;
    end
    if (accept) begin
      if (c1_v && !c1.run) begin
        busy_d[c1.bank] = 1'b1;
      end
      if (c2_v && !c2.run) begin
        busy_d[c2.bank] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q        <= BppReset;
      held_valid_q <= 1'b0;
      run_q        <= 1'b0;
      bank_q       <= 1'b0;
      len_q        <= '0;
      busy_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        bpp_q <= cfg_wdata_i;
      end
      if (accept) begin
        held_valid_q <= held_valid_d;
        run_q        <= run_d;
        bank_q       <= bank_d;
        len_q        <= len_d;
      end
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= pix;
    end
  end

endmodule

// ===== rtl/trle_cmdq.sv =====
module trle_cmdq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  trle_pkg::q_push_t push_i,
  output logic              room2_o,
  input  logic              pop_i,
  output logic              valid_o,
  output trle_pkg::cmd_t    head_o
);
  import trle_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign valid_o = cnt_q != '0;
  assign room2_o = cnt_q <= (PtrW+1)'(QueueDepth - 2);
  assign head_o  = mem_q[rd_q];

  assign cnt_d = cnt_q + (PtrW+1)'(push_i.push0) + (PtrW+1)'(push_i.push1)
                 - (PtrW+1)'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_i.push0) + PtrW'(push_i.push1);
      rd_q  <= rd_q + PtrW'(pop_i);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= push_i.cmd0;
    end
    if (push_i.push1) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.cmd1;
    end
  end

endmodule

// ===== rtl/trle_back.sv =====
module trle_back #(
  parameter int unsigned MaxPacket    = 128,
  parameter int unsigned PixPerResult = 4,
  localparam int unsigned IdxW = $clog2(MaxPacket)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  trle_pkg::cmd_t              q_head_i,
  output logic                        q_pop_o,
  output logic                        ram_re_o,
  output logic [IdxW:0]               ram_raddr_o,
  input  logic [trle_pkg::PixelW-1:0] ram_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output trle_pkg::pkt_out_t          out_data_o,
  output trle_pkg::back_stat_t        stat_o
);
  import trle_pkg::*;

  localparam int unsigned Chunk = (PixPerResult > WordsPerResult) ? WordsPerResult
                                                                   : PixPerResult;

  back_state_e          state_q, state_d;
  cmd_t                 cmd_q;
  logic [CmdCountW-1:0] sent_q, rdi_q, remaining, inflight;
  logic [CountW-1:0]    fill_q, target;
  logic                 pend_q;
  logic [PixelW-1:0]    words_q [WordsPerResult];
  logic                 out_valid_q;
  pkt_out_t             out_q, res;
  logic                 res_v, load_ok, issue, chunk_done, chunk_last;

  assign remaining  = cmd_q.count - sent_q;
  assign target     = (remaining > CmdCountW'(Chunk)) ? CountW'(Chunk)
                                                      : remaining[CountW-1:0];
  assign inflight   = rdi_q - sent_q;
  assign chunk_last = remaining == CmdCountW'(target);
  assign load_ok    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    q_pop_o    = 1'b0;
    res        = '0;
    res_v      = 1'b0;
    issue      = 1'b0;
    chunk_done = 1'b0;
    unique case (state_q)
      BackIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = BackHdr;
        end
      end
      BackHdr: begin
        res_v           = 1'b1;
        res.is_header   = 1'b1;
        res.header_byte = cmd_q.run ? (cmd_q.count + RunBias) : (cmd_q.count - HdrW'(1));
        if (load_ok) begin
          state_d = cmd_q.run ? BackRunPx : BackRaw;
        end
      end
      BackRunPx: begin
        res_v           = 1'b1;
        res.pixel_count = CountW'(1);
        res.pixel_a     = cmd_q.pixel;
        res.last_of_run = cmd_q.last_of_run;
        res.image_done  = cmd_q.image_done;
        if (load_ok) begin
          state_d = BackIdle;
        end
      end
      BackRaw: begin
        // reads for the current chunk go out one per cycle, then the chunk is offered
        issue = inflight < CmdCountW'(target);
        if (fill_q == target && !pend_q) begin
          res_v           = 1'b1;
          res.pixel_count = target;
          res.pixel_a     = (target > CountW'(0)) ? words_q[0] : '0;
          res.pixel_b     = (target > CountW'(1)) ? words_q[1] : '0;
          res.pixel_c     = (target > CountW'(2)) ? words_q[2] : '0;
          res.pixel_d     = (target > CountW'(3)) ? words_q[3] : '0;
          res.last_of_run = cmd_q.last_of_run && chunk_last;
          res.image_done  = cmd_q.image_done && chunk_last;
          if (load_ok) begin
            chunk_done = 1'b1;
            if (chunk_last) begin
              state_d = BackIdle;
            end
          end
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  assign ram_re_o    = issue;
  assign ram_raddr_o = {cmd_q.bank, rdi_q[IdxW-1:0]};

  always_comb begin
    stat_o.raw_done  = chunk_done && chunk_last;
    stat_o.done_bank = cmd_q.bank;
    stat_o.rd_active = state_q == BackRaw;
    stat_o.rd_bank   = cmd_q.bank;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      sent_q      <= '0;
      rdi_q       <= '0;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= issue;
      if (q_pop_o) begin
        sent_q <= '0;
        rdi_q  <= '0;
        fill_q <= '0;
      end else begin
        if (issue) begin
          rdi_q <= rdi_q + CmdCountW'(1);
        end
        if (pend_q) begin
          fill_q <= fill_q + CountW'(1);
        end
        if (chunk_done) begin
          sent_q <= sent_q + CmdCountW'(target);
          fill_q <= '0;
        end
      end
      if (res_v && load_ok) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_head_i;
    end
    if (pend_q) begin
      words_q[fill_q[1:0]] <= ram_rdata_i;
    end
    if (res_v && load_ok) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/tga_rle_packet_encoder.sv =====
// TGA run-length packet encoder.
// Input channel: in_valid_i / in_stall_o with in_data_i (pixel_value, image_last).
// Output channel: out_valid_o / out_stall_i with out_data_o; each packet comes out
// as one header item followed by its pixel items (run packets carry one pixel).
// cfg_we_i / cfg_wdata_i set bytes_per_pixel; write it only while the block is idle.
// The front end takes one pixel per cycle unless stalled, classifies it, stores raw
// pixels in one of two 128-entry buffer banks and posts packet commands into a 4-deep queue.
// The back end drains the queue: it fetches a command, sends the header, then the run
// pixel or the raw pixels in chunks read through the single buffer read port.
// Input stalls while fewer than two queue slots are free, or while the bank the
// front end would fill still holds a raw packet not yet read out; sustained rate
// is about one pixel per cycle on run-heavy data.
// A stalled output holds its item and backs up through the queue to the input.
// Reset empties the queue and both pipelines and sets bytes_per_pixel to 3; the
// pixel buffer needs no clearing.
module tga_rle_packet_encoder #(
  parameter int unsigned MaxPacket    = trle_pkg::MaxPacketDef,
  parameter int unsigned PixPerResult = trle_pkg::PixPerResultDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [trle_pkg::BppW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  trle_pkg::pix_in_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output trle_pkg::pkt_out_t        out_data_o
);
  import trle_pkg::*;

`include "tga_rle_packet_encoder_macros.svh"

  localparam int unsigned IdxW     = $clog2(MaxPacket);
  localparam int unsigned RamDepth = 2 * (1 << IdxW);

  q_push_t           push;
  logic              q_room, q_valid, q_pop;
  cmd_t              q_head;
  back_stat_t        bstat;
  logic              ram_we, ram_re;
  logic [IdxW:0]     ram_waddr, ram_raddr;
  logic [PixelW-1:0] ram_wdata, ram_rdata;
  logic              bank_clash, done_out, px_out, px_cnt_ok;

  trle_front #(
    .MaxPacket (MaxPacket)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_room_i    (q_room),
    .push_o      (push),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .stat_i      (bstat)
  );

  trle_ram #(
    .Width (PixelW),
    .Depth (RamDepth)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  trle_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (q_room),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  trle_back #(
    .MaxPacket    (MaxPacket),
    .PixPerResult (PixPerResult)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .stat_o      (bstat)
  );

  // front end must never overwrite the bank being read out
  assign bank_clash = ram_we && bstat.rd_active && (ram_waddr[IdxW] == bstat.rd_bank);
  assign done_out   = out_valid_o && out_data_o.image_done;
  assign px_out     = out_valid_o && !out_data_o.is_header;
  assign px_cnt_ok  = (out_data_o.pixel_count != '0) &&
                      (out_data_o.pixel_count <= CountW'(WordsPerResult));

  `TRLE_ASSERT_NEVER(a_bank_clash, bank_clash, "pixel buffer bank written while being read")
  `TRLE_ASSERT_IMPLY(a_done_is_last, done_out, out_data_o.last_of_run, "image end not on last item")
  `TRLE_ASSERT_IMPLY(a_px_count, px_out, px_cnt_ok, "pixel item with bad word count")

endmodule
